// File: rtl/rers_pkg.sv
// Package for the recent event ring search block: ring sizing, action codes
// and the layout of one stored ring entry.
// No dependencies; recent_event_ring_search uses it by scoped names.
`default_nettype none

package rers_pkg;

	localparam int RING_DEPTH = 64;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int MATCH_W    = 6;

	localparam logic [1:0] ACT_INSERT     = 2'd0;
	localparam logic [1:0] ACT_THIS_FRAME = 2'd1;
	localparam logic [1:0] ACT_WINDOW     = 2'd2;
	localparam logic [1:0] ACT_DISABLE    = 2'd3;

	typedef struct packed {
		logic signed [15:0] key;
		logic [7:0]         kind;
		logic [31:0]        frame;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// The reported slot number always has MATCH_W bits, whatever the ring depth.
	function automatic logic [MATCH_W-1:0] slot_to_match(input logic [SLOT_W-1:0] slot);
		logic [MATCH_W-1:0] res;
		res = '0;
		for (int b = 0; b < MATCH_W; b++) begin
			if (b < SLOT_W) begin
				res[b] = slot[b];
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rers_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module rers_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/recent_event_ring_search.sv
// Recent event ring search: events held in one RAM with live marks in flip-flops, searched
// backward from the newest entry one slot per cycle. Depends on rers_pkg and rers_ram.
// An insert, or a query on an empty ring, reports done in the cycle after the transfer; a query
// walks in ST_WALK (the window query first passes ST_OLDEST), each slot read from the RAM and
// checked in the stage behind it. One item at a time: busy stays high until the walk ends.
// Reset clears the live marks, write slot and fill count; the receiver cannot stall.
`default_nettype none

module recent_event_ring_search (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         action,
	input  wire logic signed [15:0] key_code,
	input  wire logic [7:0]         event_kind,
	input  wire logic [31:0]        event_frame,
	input  wire logic [31:0]        current_frame,
	input  wire logic [31:0]        window_frames,
	output logic                    done,
	output logic                    found,
	output logic [5:0]              match_slot
);

	localparam int SLOT_W = rers_pkg::SLOT_W;
	localparam int CNT_W  = rers_pkg::CNT_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_OLDEST = 2'd1;
	localparam logic [1:0] ST_WALK   = 2'd2;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(rers_pkg::RING_DEPTH - 1);
	localparam logic [CNT_W-1:0]  FILL_MAX  = CNT_W'(rers_pkg::RING_DEPTH);
	localparam logic [CNT_W:0]    DEPTH_X   = (CNT_W + 1)'(rers_pkg::RING_DEPTH);

	function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
		return (s == '0) ? SLOT_LAST : s - 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_LAST) ? '0 : s + 1'b1;
	endfunction

	logic [1:0]                    state_q;
	logic [SLOT_W-1:0]             write_slot_q;
	logic [CNT_W-1:0]              fill_q;
	logic [rers_pkg::RING_DEPTH-1:0] live_q;
	logic [SLOT_W-1:0]             rd_slot_q;
	logic [CNT_W-1:0]              walk_left_q;
	logic                          vld_s1;
	logic [SLOT_W-1:0]             slot_s1;
	logic signed [33:0]            stop_q;
	logic [1:0]                    act_q;
	logic signed [15:0]            key_q;
	logic [7:0]                    kind_q;
	logic [31:0]                   cur_q;
	logic [31:0]                   win_q;
	logic                          done_q;
	logic                          found_q;
	logic [5:0]                    match_q;

	logic                          accept;
	logic                          ins;
	logic [CNT_W:0]                old_sum;
	logic [CNT_W:0]                old_wrap;
	logic [SLOT_W-1:0]             oldest_slot;
	logic [SLOT_W-1:0]             raddr;
	logic [rers_pkg::ENTRY_W-1:0]  rdata;
	rers_pkg::entry_t              wr_entry;
	rers_pkg::entry_t              rd_entry;
	logic signed [32:0]            span;
	logic                          win_gt;
	logic signed [33:0]            cur_minus_win;
	logic                          issue;
	logic                          stop_now;
	logic                          hit_now;
	logic                          walk_end;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign ins        = accept && (action == rers_pkg::ACT_INSERT);
	assign done       = done_q;
	assign found      = found_q;
	assign match_slot = match_q;

	// Oldest filled slot: write slot minus fill count, modulo the depth.
	always_comb begin
		old_sum  = {{(CNT_W + 1 - SLOT_W){1'b0}}, write_slot_q} + DEPTH_X - {1'b0, fill_q};
		old_wrap = (old_sum >= DEPTH_X) ? old_sum - DEPTH_X : old_sum;
		oldest_slot = old_wrap[SLOT_W-1:0];
	end

	assign raddr = (state_q == ST_IDLE) ? oldest_slot : rd_slot_q;

	always_comb begin
		wr_entry.key   = key_code;
		wr_entry.kind  = event_kind;
		wr_entry.frame = event_frame;
	end

	rers_ram #(
		.WIDTH(rers_pkg::ENTRY_W),
		.DEPTH(rers_pkg::RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ins),
		.waddr(write_slot_q),
		.wdata(wr_entry),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_entry = rers_pkg::entry_t'(rdata);

	// The window is clamped to the history held: if it reaches past the oldest
	// entry, the stop frame is the oldest frame itself.
	always_comb begin
		span          = $signed({1'b0, cur_q}) - $signed({1'b0, rd_entry.frame});
		win_gt        = $signed({1'b0, win_q}) > span;
		cur_minus_win = $signed({2'b00, cur_q}) - $signed({2'b00, win_q});
	end

	always_comb begin
		issue = (walk_left_q != '0);
		if (act_q == rers_pkg::ACT_WINDOW) begin
			stop_now = $signed({2'b00, rd_entry.frame}) <= stop_q;
		end else begin
			stop_now = (rd_entry.frame != cur_q);
		end
		hit_now  = vld_s1 && !stop_now && live_q[slot_s1]
			&& (rd_entry.key == key_q) && (rd_entry.kind == kind_q);
		walk_end = (vld_s1 && (stop_now || hit_now)) || !issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			write_slot_q <= '0;
			fill_q       <= '0;
			live_q       <= '0;
			vld_s1       <= 1'b0;
			walk_left_q  <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						if (action == rers_pkg::ACT_INSERT) begin
							live_q[write_slot_q] <= 1'b1;
							write_slot_q         <= slot_inc(write_slot_q);
							if (fill_q != FILL_MAX) begin
								fill_q <= fill_q + 1'b1;
							end
							done_q <= 1'b1;
						end else if (fill_q == '0) begin
							done_q <= 1'b1;
						end else if (action == rers_pkg::ACT_WINDOW) begin
							state_q <= ST_OLDEST;
						end else begin
							walk_left_q <= fill_q;
							state_q     <= ST_WALK;
						end
					end
				end
				ST_OLDEST: begin
					walk_left_q <= fill_q;
					state_q     <= ST_WALK;
				end
				ST_WALK: begin
					vld_s1 <= issue;
					if (issue) begin
						walk_left_q <= walk_left_q - 1'b1;
					end
					if (walk_end) begin
						vld_s1  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						if (hit_now && act_q == rers_pkg::ACT_DISABLE) begin
							live_q[slot_s1] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: query operands, walk addresses and the reported result.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= action;
			key_q     <= key_code;
			kind_q    <= event_kind;
			cur_q     <= current_frame;
			win_q     <= window_frames;
			rd_slot_q <= slot_dec(write_slot_q);
			found_q   <= 1'b0;
			match_q   <= '0;
		end
		if (state_q == ST_OLDEST) begin
			stop_q <= win_gt ? $signed({2'b00, rd_entry.frame}) : cur_minus_win;
		end
		if (state_q == ST_WALK) begin
			slot_s1 <= rd_slot_q;
			if (issue) begin
				rd_slot_q <= slot_dec(rd_slot_q);
			end
			if (walk_end) begin
				found_q <= hit_now;
				match_q <= hit_now ? rers_pkg::slot_to_match(slot_s1) : '0;
			end
		end
	end

endmodule

`default_nettype wire
